@@ rtl/qte_pkg.sv @@
`default_nettype none
package qte_pkg;

    localparam int QUAT_WIDTH_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TAB_LEN           = 24;
    // Width of the vectors handed to the CORDIC units; the angle accumulator (ZW) has the same width.
    localparam int VEC_W             = 34;
    localparam int CW                = 36;
    localparam int ZW                = 34;
    // One integer square root step per stage, 64-bit radicand.
    localparam int SQ_STEPS          = 32;
    localparam int FRONT_LAT         = 4;
    localparam int OUT_LAT           = 2;

    localparam logic [30:0] ATAN_TAB [TAB_LEN] = '{
        31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
        31'd67021686,  31'd33543515,  31'd16775850,  31'd8388437,
        31'd4194282,   31'd2097149,   31'd1048575,   31'd524287,
        31'd262143,    31'd131071,    31'd65535,     31'd32767,
        31'd16383,     31'd8191,      31'd4095,      31'd2047,
        31'd1023,      31'd511,       31'd255,       31'd127
    };

    localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd1686629713;
    localparam logic [21:0] RAD2DEG_Q16 = 22'd3754936;

    typedef struct packed {
        logic signed [VEC_W-1:0] yaw_y;
        logic signed [VEC_W-1:0] yaw_x;
        logic signed [VEC_W-1:0] roll_y;
        logic signed [VEC_W-1:0] roll_x;
        logic signed [VEC_W-1:0] pitch_y;
        logic                    inv;
    } t_side;

    typedef struct packed {
        logic               inv;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } t_res;

endpackage
`default_nettype wire

@@ rtl/qte_front.sv @@
`default_nettype none
module qte_front #(
    parameter int QUAT_WIDTH = qte_pkg::QUAT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [QUAT_WIDTH-1:0] i_quat_real,
    input  wire logic [QUAT_WIDTH-1:0] i_quat_i,
    input  wire logic [QUAT_WIDTH-1:0] i_quat_j,
    input  wire logic [QUAT_WIDTH-1:0] i_quat_k,
    output logic [63:0]                o_prod,
    output qte_pkg::t_side             o_side
);
    import qte_pkg::*;

    logic [QUAT_WIDTH-1:0] w_raw [4];
    logic signed [15:0]    w_q   [4];

    assign w_raw[0] = i_quat_real;
    assign w_raw[1] = i_quat_i;
    assign w_raw[2] = i_quat_j;
    assign w_raw[3] = i_quat_k;

    // Wider inputs keep their top 16 bits, which is an arithmetic right shift.
    for (genvar g = 0; g < 4; g++) begin : g_red
        if (QUAT_WIDTH > 16) begin : g_wide
            assign w_q[g] = w_raw[g][QUAT_WIDTH-1 -: 16];
        end else begin : g_narrow
            assign w_q[g] = 16'($signed(w_raw[g]));
        end
    end

    // Stage 1: squares and cross products.
    logic signed [31:0] r_sq [4];
    logic signed [31:0] r_ij, r_kr, r_jk, r_ir, r_jr, r_ik;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_sq[k] <= w_q[k] * w_q[k];
            end
            r_ij <= w_q[1] * w_q[2];
            r_kr <= w_q[3] * w_q[0];
            r_jk <= w_q[2] * w_q[3];
            r_ir <= w_q[1] * w_q[0];
            r_jr <= w_q[2] * w_q[0];
            r_ik <= w_q[1] * w_q[3];
        end
    end

    // Stage 2: norm and the atan2 operands.
    logic [32:0]             r_norm;
    logic signed [VEC_W-1:0] r_yy, r_yx, r_ry, r_rx, r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_norm <= {1'b0, r_sq[0]} + {1'b0, r_sq[1]} + {1'b0, r_sq[2]} + {1'b0, r_sq[3]};
            r_yy   <= (VEC_W'(r_ij) + VEC_W'(r_kr)) <<< 1;
            r_yx   <= VEC_W'(r_sq[0]) + VEC_W'(r_sq[1]) - VEC_W'(r_sq[2]) - VEC_W'(r_sq[3]);
            r_ry   <= (VEC_W'(r_jk) + VEC_W'(r_ir)) <<< 1;
            r_rx   <= VEC_W'(r_sq[0]) - VEC_W'(r_sq[1]) - VEC_W'(r_sq[2]) + VEC_W'(r_sq[3]);
            r_p    <= (VEC_W'(r_jr) - VEC_W'(r_ik)) <<< 1;
        end
    end

    // Stage 3: clamp the sine term to the norm and scale both into 32 bits.
    logic [VEC_W-1:0]  n_pa_abs;
    logic [VEC_W-1:0]  n_pa_clamp;
    logic [32:0]       n_norm_h;
    logic [32:0]       n_pa_h;
    logic              n_big;

    always_comb begin
        n_pa_abs   = r_p[VEC_W-1] ? VEC_W'(-r_p) : VEC_W'(r_p);
        n_pa_clamp = (n_pa_abs > {1'b0, r_norm}) ? {1'b0, r_norm} : n_pa_abs;
        n_big      = r_norm[32] | r_norm[31];
        n_norm_h   = n_big ? (r_norm >> 1) : r_norm;
        n_pa_h     = n_big ? n_pa_clamp[33:1] : n_pa_clamp[32:0];
    end

    logic [31:0] r_diff;
    logic [32:0] r_sum;
    t_side       r_side3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff          <= 32'(n_norm_h - n_pa_h);
            r_sum           <= n_norm_h + n_pa_h;
            r_side3.yaw_y   <= r_yy;
            r_side3.yaw_x   <= r_yx;
            r_side3.roll_y  <= r_ry;
            r_side3.roll_x  <= r_rx;
            r_side3.pitch_y <= r_p[VEC_W-1] ? -$signed({1'b0, n_pa_h})
                                            : $signed({1'b0, n_pa_h});
            r_side3.inv     <= (r_norm == '0);
        end
    end

    // Stage 4: radicand for the cosine of pitch.
    logic [63:0] r_prod;
    t_side       r_side4;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= 64'(r_diff * r_sum);
            r_side4 <= r_side3;
        end
    end

    assign o_prod = r_prod;
    assign o_side = r_side4;

endmodule
`default_nettype wire

@@ rtl/qte_isqrt.sv @@
`default_nettype none
module qte_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_v,
    output logic [31:0]      o_root
);
    import qte_pkg::*;

    logic [63:0] r_v [SQ_STEPS];
    logic [63:0] r_r [SQ_STEPS];

    // Each stage tries one result bit, from bit 31 down to bit 0.
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
        logic [63:0] w_v_in;
        logic [63:0] w_r_in;
        logic [63:0] w_try;
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);

        if (g == 0) begin : g_first
            assign w_v_in = i_v;
            assign w_r_in = '0;
        end else begin : g_next
            assign w_v_in = r_v[g-1];
            assign w_r_in = r_r[g-1];
        end

        assign w_try = w_r_in + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_v_in >= w_try) begin
                    r_v[g] <= w_v_in - w_try;
                    r_r[g] <= (w_r_in >> 1) + BIT;
                end else begin
                    r_v[g] <= w_v_in;
                    r_r[g] <= w_r_in >> 1;
                end
            end
        end
    end

    assign o_root = r_r[SQ_STEPS-1][31:0];

endmodule
`default_nettype wire

@@ rtl/qte_cordic.sv @@
`default_nettype none
module qte_cordic #(
    parameter int NSTG = qte_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic signed [qte_pkg::VEC_W-1:0] i_y,
    input  wire logic signed [qte_pkg::VEC_W-1:0] i_x,
    output logic signed [qte_pkg::ZW-1:0]        o_z
);
    import qte_pkg::*;

    logic signed [CW-1:0] r_x [NSTG+1];
    logic signed [CW-1:0] r_y [NSTG+1];
    logic signed [ZW-1:0] r_z [NSTG+1];
    logic                 r_zero [NSTG+1];

    logic signed [CW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;
    logic signed [CW-1:0] w_xe, w_ye;

    assign w_xe = CW'(i_x);
    assign w_ye = CW'(i_y);

    // A vector in the left half plane is turned by a quarter turn first.
    always_comb begin
        n_x = w_xe;
        n_y = w_ye;
        n_z = '0;
        if (w_xe < 0) begin
            if (w_ye >= 0) begin
                n_x = w_ye;
                n_y = -w_xe;
                n_z = ANG_HALF_PI;
            end else begin
                n_x = -w_ye;
                n_y = w_xe;
                n_z = -ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_z[0]    <= n_z;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    for (genvar g = 0; g < NSTG; g++) begin : g_rot
        logic signed [ZW-1:0] w_ang;
        assign w_ang = $signed({3'b000, ATAN_TAB[g]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[g+1] <= r_zero[g];
                if (r_y[g] > 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + w_ang;
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - w_ang;
                end
            end
        end
    end

    // The zero vector has no direction; its angle is defined as zero.
    assign o_z = r_zero[NSTG] ? '0 : r_z[NSTG];

endmodule
`default_nettype wire

@@ rtl/qte_out.sv @@
`default_nettype none
module qte_out (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic                         i_deg,
    input  wire logic signed [qte_pkg::ZW-1:0] i_z,
    output logic signed [15:0]                o_angle
);
    import qte_pkg::*;

    localparam int PW = ZW + 23;

    logic signed [ZW-1:0] r_z;
    logic signed [PW-1:0] r_prod;
    logic                 r_deg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z    <= i_z;
            r_prod <= PW'(i_z) * PW'($signed({1'b0, RAD2DEG_Q16}));
            r_deg  <= i_deg;
        end
    end

    logic signed [PW-1:0]   w_dr;
    logic signed [ZW:0]     w_rr;
    logic signed [17:0]     w_sel;
    logic signed [15:0]     n_angle;

    // Round half up: degrees drop 39 bits, radians drop 17 bits.
    always_comb begin
        w_dr  = r_prod + (PW'(1) <<< 38);
        w_rr  = (ZW+1)'(r_z) + (ZW+1)'(65536);
        w_sel = r_deg ? w_dr[56:39] : w_rr[34:17];
        if (w_sel > 18'sd32767) begin
            n_angle = 16'sh7fff;
        end else if (w_sel < -18'sd32768) begin
            n_angle = 16'sh8000;
        end else begin
            n_angle = w_sel[15:0];
        end
    end

    logic signed [15:0] r_angle;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule
`default_nettype wire

@@ rtl/quaternion_to_euler_angles_top.sv @@
// Quaternion to Z-Y-X Euler angles (yaw, pitch, roll), fully pipelined.
// Input stream: one word per quaternion, fields real, i, j, k of QUAT_WIDTH bits
// each in signed Q14, real in the lowest bits. Output stream: one word per
// quaternion with yaw, pitch and roll as signed 16-bit angles, yaw lowest, and
// tuser carrying the zero-norm flag (angles are then zero).
// The angles are radians Q13, or degrees Q7 while i_cfg_wdata was last written
// as 1 through i_cfg_we. Change the unit only while the pipeline is empty.
// Throughput is one word per cycle while the output is not stalled. The
// pipeline holds four front stages of multiplies and sums, 32 square root
// stages, one quadrant stage plus one stage per CORDIC rotation (CORDIC_STAGES
// above 24 count as 24), two output conversion stages and the output register.
// Reset empties the pipeline and selects radians. When the receiver stalls,
// words move on until one is caught in a one-word skid buffer behind the
// output register; the full buffer then drops s_axis_tready and holds the
// whole pipeline, so no word is lost.
`default_nettype none
module quaternion_to_euler_angles_top #(
    parameter int QUAT_WIDTH    = qte_pkg::QUAT_WIDTH_DEF,
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic                                   i_cfg_wdata,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // quat_real, quat_i, quat_j, quat_k, zero fill
    input  wire logic [((4*QUAT_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // yaw_angle, pitch_angle, roll_angle
    output logic [47:0]                                 m_axis_tdata,
    // norm_invalid
    output logic [0:0]                                  m_axis_tuser
);
    import qte_pkg::*;

    localparam int NSTG    = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
    localparam int LAT     = FRONT_LAT + SQ_STEPS + 1 + NSTG + OUT_LAT;
    localparam int INV_LEN = NSTG + 1 + OUT_LAT;

    logic r_deg;
    logic r_skid_vld;
    logic r_ovld;
    logic w_en;
    logic w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= 1'b0;
        end else if (i_cfg_we) begin
            r_deg <= i_cfg_wdata;
        end
    end

    assign w_en          = !r_skid_vld;
    assign s_axis_tready = w_en;

    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    assign w_push = w_en && r_vld[LAT-1];

    logic [63:0] w_prod;
    t_side       w_side;
    logic [31:0] w_root;

    qte_front #(
        .QUAT_WIDTH (QUAT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_quat_real (s_axis_tdata[0*QUAT_WIDTH +: QUAT_WIDTH]),
        .i_quat_i    (s_axis_tdata[1*QUAT_WIDTH +: QUAT_WIDTH]),
        .i_quat_j    (s_axis_tdata[2*QUAT_WIDTH +: QUAT_WIDTH]),
        .i_quat_k    (s_axis_tdata[3*QUAT_WIDTH +: QUAT_WIDTH]),
        .o_prod      (w_prod),
        .o_side      (w_side)
    );

    qte_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_v    (w_prod),
        .o_root (w_root)
    );

    // Operands that wait beside the square root.
    t_side r_side [SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    logic [INV_LEN-1:0] r_inv;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_inv <= {r_inv[INV_LEN-2:0], r_side[SQ_STEPS-1].inv};
        end
    end

    logic signed [ZW-1:0] w_z_yaw, w_z_pitch, w_z_roll;
    logic signed [15:0]   w_yaw, w_pitch, w_roll;

    qte_cordic #(.NSTG(NSTG)) u_cordic_yaw (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_side[SQ_STEPS-1].yaw_y),
        .i_x   (r_side[SQ_STEPS-1].yaw_x),
        .o_z   (w_z_yaw)
    );

    qte_cordic #(.NSTG(NSTG)) u_cordic_pitch (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_side[SQ_STEPS-1].pitch_y),
        .i_x   ($signed({2'b00, w_root})),
        .o_z   (w_z_pitch)
    );

    qte_cordic #(.NSTG(NSTG)) u_cordic_roll (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_side[SQ_STEPS-1].roll_y),
        .i_x   (r_side[SQ_STEPS-1].roll_x),
        .o_z   (w_z_roll)
    );

    qte_out u_out_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_deg   (r_deg),
        .i_z     (w_z_yaw),
        .o_angle (w_yaw)
    );

    qte_out u_out_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_deg   (r_deg),
        .i_z     (w_z_pitch),
        .o_angle (w_pitch)
    );

    qte_out u_out_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_deg   (r_deg),
        .i_z     (w_z_roll),
        .o_angle (w_roll)
    );

    t_res w_item;

    always_comb begin
        w_item.inv   = r_inv[INV_LEN-1];
        w_item.yaw   = w_item.inv ? '0 : w_yaw;
        w_item.pitch = w_item.inv ? '0 : w_pitch;
        w_item.roll  = w_item.inv ? '0 : w_roll;
    end

    // Output register with a one-word skid buffer.
    t_res r_odata;
    t_res r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld     <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_ovld && !m_axis_tready) begin
            if (w_push) begin
                r_skid     <= w_item;
                r_skid_vld <= 1'b1;
            end
        end else if (r_skid_vld) begin
            r_odata    <= r_skid;
            r_ovld     <= 1'b1;
            r_skid_vld <= 1'b0;
        end else begin
            r_ovld <= w_push;
            if (w_push) begin
                r_odata <= w_item;
            end
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {r_odata.roll, r_odata.pitch, r_odata.yaw};
    assign m_axis_tuser  = r_odata.inv;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_ovld)
        else $error("skid buffer holds a word while the output register is empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !m_axis_tready && w_push) |=> r_skid_vld)
        else $error("word leaving the pipeline during a stall was not caught");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("zero-norm word carries nonzero angles");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_skid_vld) && r_skid_vld |-> !s_axis_tready)
        else $error("input accepted while the skid buffer is full");
`endif

endmodule
`default_nettype wire

@@ bench/quaternion_to_euler_angles_top_tb.sv @@
`timescale 1ns / 1ps
module quaternion_to_euler_angles_top_tb;
    import qte_pkg::*;

    localparam int  STAGES      = 16;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN       = 80;
    localparam longint HALF_PI  = 64'sd1686629713;
    localparam longint DEG_Q16  = 64'sd3754936;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    logic        use_degrees;
    logic        quiet_send;
    logic        quiet_recv;
    logic [3:0]  recv_hold;
    int          cycle_count;

    quaternion_to_euler_angles_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    class euler_scoreboard;
        t_res angles_due[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function void report(string msg);
            $display("angle check: %s", msg);
            errors++;
        endfunction

        function int pending();
            return angles_due.size();
        endfunction

        // Vectoring CORDIC, angle in Q30 radians.
        function longint vector_angle(longint y, longint x);
            longint z;
            longint t;
            longint dx;
            longint dy;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = HALF_PI;
                end else begin
                    x = -y; y = t; z = -HALF_PI;
                end
            end
            for (int i = 0; i < STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
                end else begin
                    x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
                end
            end
            return z;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v  -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function logic signed [15:0] scale_angle(longint z, logic deg);
            longint r;
            if (deg) r = (z * DEG_Q16 + (64'sd1 <<< 38)) >>> 39;
            else     r = (z + (64'sd1 <<< 16)) >>> 17;
            if (r > 32767)  r = 32767;
            if (r < -32768) r = -32768;
            return r[15:0];
        endfunction

        function void note_quat(logic [63:0] word, logic deg);
            longint qr, qi, qj, qk, sr, si, sj, sk, p;
            longint unsigned n, pa, s;
            logic   neg;
            t_res   e;
            qr = longint'($signed(word[15:0]));
            qi = longint'($signed(word[31:16]));
            qj = longint'($signed(word[47:32]));
            qk = longint'($signed(word[63:48]));
            sr = qr * qr; si = qi * qi; sj = qj * qj; sk = qk * qk;
            n  = sr + si + sj + sk;
            e  = '0;
            if (n == 0) begin
                e.inv = 1'b1;
            end else begin
                e.yaw  = scale_angle(vector_angle(2 * (qi * qj + qk * qr),
                                                  si - sj - sk + sr), deg);
                e.roll = scale_angle(vector_angle(2 * (qj * qk + qi * qr),
                                                  -si - sj + sk + sr), deg);
                p   = 2 * (qj * qr - qi * qk);
                neg = p < 0;
                pa  = neg ? -p : p;
                if (pa > n) pa = n;
                // Keep the radicand product inside 64 bits for big norms.
                if (n >= (64'd1 << 31)) begin
                    n >>= 1;
                    pa >>= 1;
                end
                s = int_sqrt((n - pa) * (n + pa));
                e.pitch = scale_angle(vector_angle(neg ? -longint'(pa) : longint'(pa),
                                                   longint'(s)), deg);
            end
            angles_due.push_back(e);
        endfunction

        function void check_angles(logic [47:0] data, logic inv);
            t_res e;
            if (angles_due.size() == 0) begin
                report($sformatf("unexpected word %h user %b", data, inv));
                return;
            end
            e = angles_due.pop_front();
            if ($signed(data[15:0]) != e.yaw)
                report($sformatf("yaw %0d, want %0d", $signed(data[15:0]), e.yaw));
            if ($signed(data[31:16]) != e.pitch)
                report($sformatf("pitch %0d, want %0d", $signed(data[31:16]), e.pitch));
            if ($signed(data[47:32]) != e.roll)
                report($sformatf("roll %0d, want %0d", $signed(data[47:32]), e.roll));
            if (inv != e.inv)
                report($sformatf("norm_invalid %b, want %b", inv, e.inv));
        endfunction
    endclass

    euler_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: after an accepted word, sometimes stall for a random number of cycles, unless quiet_recv is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_hold     <= '0;
        end else if (recv_hold != 0) begin
            recv_hold <= recv_hold - 1;
            if (recv_hold == 1) m_axis_tready <= 1'b1;
        end else if (m_axis_tready && m_axis_tvalid) begin
            if (!quiet_recv && $urandom_range(0, 1) == 1) begin
                m_axis_tready <= 1'b0;
                recv_hold     <= 4'($urandom_range(1, 7));
            end
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_angles(m_axis_tdata, m_axis_tuser[0]);
    end

    task automatic send_quat(logic [63:0] word);
        int gap;
        gap = quiet_send ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_quat(word, use_degrees);
    endtask

    task automatic set_unit(logic deg);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= deg;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        use_degrees = deg;
    endtask

    function automatic logic [15:0] pick_comp(int mode);
        int pool [7] = '{-32768, 32767, 0, -1, 1, 16384, -16384};
        case (mode)
            0, 1, 2, 3: return 16'($urandom);
            4, 5:       return 16'($urandom_range(0, 6) - 3);
            6:          return ($urandom_range(0, 1) == 1) ? 16'd0 : 16'($urandom);
            7:          return 16'(pool[$urandom_range(0, 6)]);
            default:    return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    task automatic send_random(int count);
        int mode;
        for (int k = 0; k < count; k++) begin
            if (k % 60 == 0) begin
                quiet_send = ($urandom_range(0, 3) == 0);
                quiet_recv = ($urandom_range(0, 3) == 0);
            end
            mode = $urandom_range(0, 8);
            send_quat({pick_comp(mode), pick_comp(mode), pick_comp(mode), pick_comp(mode)});
        end
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
    endtask

    task automatic send_directed();
        logic [63:0] words [$];
        // Fields from the top down: k, j, i, real.
        words = '{
            {16'd0, 16'd0, 16'd0, 16'd0},                     // zero norm
            {16'd0, 16'd0, 16'd0, 16'd16384},                 // identity
            {16'd0, 16'd0, 16'd16384, 16'd0},
            {16'd0, 16'd16384, 16'd0, 16'd0},
            {16'd16384, 16'd0, 16'd0, 16'd0},
            {16'd0, 16'd8192, 16'd0, 16'd8192},               // pitch at +90 degrees
            {16'd0, -16'sd8192, 16'd0, 16'd8192},             // pitch at -90 degrees
            {-16'sd3000, 16'd5000, 16'd3000, 16'd5000},       // gimbal lock
            {16'h8000, 16'h8000, 16'h8000, 16'h8000},         // largest norm
            {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
            {16'h7fff, 16'h8000, 16'h7fff, 16'h8000},
            {16'h8000, 16'h0000, 16'h0000, 16'h0000},
            {16'h0000, 16'h0000, 16'h0000, 16'h8000},
            {16'hffff, 16'hffff, 16'hffff, 16'hffff},
            {16'd0, 16'd0, 16'd0, 16'd1},
            {16'd0, 16'd0, 16'd0, 16'hffff},
            {16'd1, 16'd0, 16'd0, 16'd0},
            {16'd11585, 16'd0, 16'd0, 16'd11585},
            {16'd0, 16'd0, 16'd11585, 16'd11585},
            {16'd8192, 16'd8192, 16'd8192, 16'd8192},
            {16'h7fff, 16'h0000, 16'h0000, 16'h0000},
            {16'h1234, 16'h8765, 16'h4321, 16'hfedc}
        };
        foreach (words[w]) send_quat(words[w]);
    endtask

    initial begin
        sb            = new();
        cycle_count   = 0;
        use_degrees   = 1'b0;
        quiet_send    = 1'b0;
        quiet_recv    = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < 4; ph++) begin
            set_unit(ph[0]);
            if (ph < 2) send_directed();
            send_random(320);
        end
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
